// ===== rtl/core/rotenc_pkg.sv =====
// rotary encoder decoder package: widths, phase codes, event codes and result structs
// no dependencies; imported by the report interface and every module of the block
`timescale 1ns / 1ps

package rotenc_pkg;

	// widths
	localparam int TIMER_WIDTH    = 16;
	localparam int DEB_WIDTH      = 16;
	localparam int APB_ADDR_WIDTH = 3;
	localparam int APB_DATA_WIDTH = 32;

	// register map (index taken from paddr[2])
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RESET = 16'd7;

	// rotation phases
	localparam logic [2:0] RP_IDLE       = 3'd0;
	localparam logic [2:0] RP_A_FALLWAIT = 3'd1;
	localparam logic [2:0] RP_B_FALLWAIT = 3'd2;
	localparam logic [2:0] RP_A_LOW      = 3'd3;
	localparam logic [2:0] RP_B_LOW      = 3'd4;
	localparam logic [2:0] RP_A_RISEWAIT = 3'd5;
	localparam logic [2:0] RP_B_RISEWAIT = 3'd6;

	// switch phases
	localparam logic [1:0] SP_HIGH     = 2'd0;
	localparam logic [1:0] SP_FALLWAIT = 2'd1;
	localparam logic [1:0] SP_LOW      = 2'd2;
	localparam logic [1:0] SP_RISEWAIT = 2'd3;

	// event codes
	localparam logic [1:0] TWIST_NONE = 2'd0;
	localparam logic [1:0] TWIST_CW   = 2'd1;
	localparam logic [1:0] TWIST_ACW  = 2'd2;
	localparam logic [1:0] SW_NONE    = 2'd0;
	localparam logic [1:0] SW_PRESS   = 2'd1;
	localparam logic [1:0] SW_RELEASE = 2'd2;
	localparam logic DIR_CW  = 1'b0;
	localparam logic DIR_ACW = 1'b1;

	typedef logic [TIMER_WIDTH-1:0] timer_t;
	typedef logic [DEB_WIDTH-1:0]   deb_t;
	typedef logic [1:0]             code_t;

	typedef struct packed {
		timer_t count;
		logic   done;
	} wait_t;

	typedef struct packed {
		code_t twist;
		logic  direction;
	} rot_res_t;

	typedef struct packed {
		code_t ev;
		logic  level;
	} sw_res_t;

	// saturating wait counter step; done when the count reaches the debounce setting or saturates
	function automatic wait_t wait_step(timer_t t, deb_t deb);
		wait_t       r;
		logic [31:0] cnt_x;
		logic [31:0] deb_x;
		r.count = (t == '1) ? t : t + timer_t'(1);
		cnt_x   = 32'(r.count);
		deb_x   = 32'(deb);
		r.done  = (cnt_x >= deb_x) || (r.count == '1);
		return r;
	endfunction

endpackage

// ===== rtl/core/rotenc_sample_if.sv =====
// sample channel: valid/ready handshake carrying one tick of pin levels
// no dependencies
`timescale 1ns / 1ps

interface rotenc_sample_if;
	logic valid;
	logic ready;
	logic pin_a;
	logic pin_b;
	logic pin_push;

	modport source (output valid, output pin_a, output pin_b, output pin_push, input ready);
	modport sink (input valid, input pin_a, input pin_b, input pin_push, output ready);
endinterface

// ===== rtl/core/rotenc_report_if.sv =====
// report channel: valid/ready handshake carrying the events of one tick
// depends on rotenc_pkg
`timescale 1ns / 1ps

interface rotenc_report_if import rotenc_pkg::*;;
	logic  valid;
	logic  ready;
	code_t twist_event;
	code_t switch_event;
	logic  last_direction;
	logic  switch_level;

	modport source (output valid, output twist_event, output switch_event,
		output last_direction, output switch_level, input ready);
	modport sink (input valid, input twist_event, input switch_event,
		input last_direction, input switch_level, output ready);
endinterface

// ===== rtl/core/rotenc_apb.sv =====
// apb register slave holding the debounce setting
// depends on rotenc_pkg
`timescale 1ns / 1ps

module rotenc_apb import rotenc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0] prdata,
	output logic                      pready,
	output deb_t                      deb
);

	deb_t deb_q;
	logic hit;

	assign hit    = (paddr[2] == REG_DEBOUNCE);
	assign pready = 1'b1;
	assign deb    = deb_q;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q <= DEBOUNCE_RESET;
		end else if (psel && penable && pwrite && hit) begin
			deb_q <= pwdata[DEB_WIDTH-1:0];
		end
	end

	// read data
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = APB_DATA_WIDTH'(deb_q);
		end
	end

endmodule

// ===== rtl/core/rotenc_rot.sv =====
// rotation debounce state machine: channel ownership, edge confirmation, twist events
// depends on rotenc_pkg
`timescale 1ns / 1ps

module rotenc_rot import rotenc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  logic     pin_a,
	input  logic     pin_b,
	input  deb_t     deb,
	output rot_res_t res
);

	logic [2:0] phase_q;
	logic [2:0] phase_d;
	timer_t     timer_q;
	timer_t     timer_d;
	logic       dir_q;
	logic       dir_d;
	code_t      twist;
	wait_t      w;

	// next state for one tick
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		dir_d   = dir_q;
		twist   = TWIST_NONE;
		w       = wait_step(timer_q, deb);
		unique case (phase_q)
			RP_A_FALLWAIT: begin
				timer_d = w.count;
				if (w.done) begin
					if (!pin_a) begin
						phase_d = RP_A_LOW;
						dir_d   = DIR_ACW;
					end else begin
						phase_d = RP_IDLE;
					end
				end
			end
			RP_B_FALLWAIT: begin
				timer_d = w.count;
				if (w.done) begin
					if (!pin_b) begin
						phase_d = RP_B_LOW;
						dir_d   = DIR_CW;
					end else begin
						phase_d = RP_IDLE;
					end
				end
			end
			RP_A_LOW: begin
				if (pin_a) begin
					phase_d = RP_A_RISEWAIT;
					timer_d = '0;
				end
			end
			RP_B_LOW: begin
				if (pin_b) begin
					phase_d = RP_B_RISEWAIT;
					timer_d = '0;
				end
			end
			RP_A_RISEWAIT: begin
				timer_d = w.count;
				if (w.done) begin
					if (pin_a) begin
						phase_d = RP_IDLE;
						twist   = TWIST_ACW;
					end else begin
						phase_d = RP_A_LOW;
					end
				end
			end
			RP_B_RISEWAIT: begin
				timer_d = w.count;
				if (w.done) begin
					if (pin_b) begin
						phase_d = RP_IDLE;
						twist   = TWIST_CW;
					end else begin
						// owner stays B, A remains locked out
						phase_d = RP_B_LOW;
					end
				end
			end
			default: begin
				// idle and unused codes: first low channel takes ownership, A wins ties
				phase_d = RP_IDLE;
				if (!pin_a) begin
					phase_d = RP_A_FALLWAIT;
					timer_d = '0;
				end else if (!pin_b) begin
					phase_d = RP_B_FALLWAIT;
					timer_d = '0;
				end
			end
		endcase
		res.twist     = twist;
		res.direction = dir_d;
	end

	// state update once per processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RP_IDLE;
			timer_q <= '0;
			dir_q   <= DIR_CW;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			dir_q   <= dir_d;
		end
	end

endmodule

// ===== rtl/core/rotenc_sw.sv =====
// push switch debounce state machine: press and release events, debounced level
// depends on rotenc_pkg
`timescale 1ns / 1ps

module rotenc_sw import rotenc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic    pin_push,
	input  deb_t    deb,
	output sw_res_t res
);

	logic [1:0] phase_q;
	logic [1:0] phase_d;
	timer_t     timer_q;
	timer_t     timer_d;
	code_t      ev;
	wait_t      w;

	// next state for one tick
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		ev      = SW_NONE;
		w       = wait_step(timer_q, deb);
		unique case (phase_q)
			SP_FALLWAIT: begin
				timer_d = w.count;
				if (w.done) begin
					if (!pin_push) begin
						phase_d = SP_LOW;
						ev      = SW_PRESS;
					end else begin
						phase_d = SP_HIGH;
					end
				end
			end
			SP_LOW: begin
				if (pin_push) begin
					phase_d = SP_RISEWAIT;
					timer_d = '0;
				end
			end
			SP_RISEWAIT: begin
				timer_d = w.count;
				if (w.done) begin
					if (pin_push) begin
						phase_d = SP_HIGH;
						ev      = SW_RELEASE;
					end else begin
						phase_d = SP_LOW;
					end
				end
			end
			default: begin
				// high, waiting for a fall
				if (!pin_push) begin
					phase_d = SP_FALLWAIT;
					timer_d = '0;
				end
			end
		endcase
		res.ev    = ev;
		res.level = (phase_d == SP_HIGH) || (phase_d == SP_FALLWAIT);
	end

	// state update once per processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= SP_HIGH;
			timer_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
		end
	end

endmodule

// ===== rtl/core/rotary_encoder_debounce_decoder.sv =====
// Rotary encoder quadrature decoder with debounce, top level.
// Depends on rotenc_pkg, rotenc_sample_if, rotenc_report_if, rotenc_apb, rotenc_rot, rotenc_sw.
//
// Usage:
//   sample (sink): one transaction per sampling tick with pin_a, pin_b, pin_push.
//   report (source): exactly one transaction per sample with twist_event,
//     switch_event, last_direction and switch_level after that tick.
//   APB port: register 0 at byte address 0 is debounce_ticks (16 bits, reset 7), which the user
//     must write only with no sample in flight, unchecked by the block. pready is tied high.
// Processing: a sample accepted into the input register is processed when it moves into the
//   report register, which may wait on a stall; its report is valid from then on.
// Throughput: one sample per cycle while report.ready is high; the input and report
//   registers form a two-stage elastic pipeline with a single state update per sample.
// Reset: arst_n clears both state machines to idle/high, timers to zero,
//   direction to clockwise, debounce_ticks to 7, and empties the pipeline.
// Stall: when report.ready is low with a report pending, the report register holds,
//   one more sample is taken into the input register if it is empty, then
//   sample.ready drops until the report is taken.
`timescale 1ns / 1ps

module rotary_encoder_debounce_decoder import rotenc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	rotenc_sample_if.sink             sample,
	rotenc_report_if.source           report,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0] prdata,
	output logic                      pready
);

	deb_t     deb;
	logic     valid_s1;
	logic     pin_a_s1;
	logic     pin_b_s1;
	logic     pin_push_s1;
	logic     valid_s2;
	rot_res_t rot_s2;
	sw_res_t  sw_s2;
	rot_res_t rot_res;
	sw_res_t  sw_res;
	logic     adv_s2;
	logic     step;

	// pipeline flow control
	assign adv_s2       = !valid_s2 || report.ready;
	assign step         = valid_s1 && adv_s2;
	assign sample.ready = !valid_s1 || adv_s2;

	rotenc_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.deb     (deb)
	);

	rotenc_rot u_rot (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pin_a  (pin_a_s1),
		.pin_b  (pin_b_s1),
		.deb    (deb),
		.res    (rot_res)
	);

	rotenc_sw u_sw (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.pin_push (pin_push_s1),
		.deb      (deb),
		.res      (sw_res)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			pin_a_s1    <= sample.pin_a;
			pin_b_s1    <= sample.pin_b;
			pin_push_s1 <= sample.pin_push;
		end
	end

	// report register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// report register payload
	always_ff @(posedge clk) begin
		if (step) begin
			rot_s2 <= rot_res;
			sw_s2  <= sw_res;
		end
	end

	// report channel
	assign report.valid          = valid_s2;
	assign report.twist_event    = rot_s2.twist;
	assign report.last_direction = rot_s2.direction;
	assign report.switch_event   = sw_s2.ev;
	assign report.switch_level   = sw_s2.level;

endmodule

// ===== rtl/core/rotenc_checker.sv =====
// port-level checks for the rotary encoder decoder, bound to the top level
// depends on rotenc_pkg and rotary_encoder_debounce_decoder
`timescale 1ns / 1ps

module rotenc_checker import rotenc_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  rep_valid,
	input logic  rep_ready,
	input code_t twist_event,
	input code_t switch_event,
	input logic  last_direction,
	input logic  switch_level
);

	// a stalled report keeps its events
	assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && !rep_ready |=> rep_valid && $stable(twist_event)
			&& $stable(switch_event) && $stable(last_direction) && $stable(switch_level))
		else $error("report changed while stalled");

	// twist direction agrees with the latched direction
	assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && (twist_event == TWIST_ACW) |-> last_direction == DIR_ACW)
		else $error("anticlockwise twist with clockwise direction");

	assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && (twist_event == TWIST_CW) |-> last_direction == DIR_CW)
		else $error("clockwise twist with anticlockwise direction");

	// switch events agree with the debounced level
	assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && (switch_event != SW_NONE) |->
			((switch_event == SW_PRESS) && !switch_level)
			|| ((switch_event == SW_RELEASE) && switch_level))
		else $error("switch event inconsistent with level");

endmodule

bind rotary_encoder_debounce_decoder rotenc_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rep_valid      (report.valid),
	.rep_ready      (report.ready),
	.twist_event    (report.twist_event),
	.switch_event   (report.switch_event),
	.last_direction (report.last_direction),
	.switch_level   (report.switch_level)
);

// ===== verif/tb.sv =====
// testbench for the rotary encoder decoder: random and directed pin ticks,
// per-tick report prediction in a scoreboard class, and debounce register writes over APB
// depends on rotenc_pkg, rotenc_sample_if, rotenc_report_if and the rtl top level
`timescale 1ns / 1ps

module tb;
	import rotenc_pkg::*;

	localparam int   HOLD_CYCLES    = 80;
	localparam int   DRAIN_CYCLES   = 4;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   MAX_SHOWN      = 100;
	localparam logic REG_UNUSED     = 1'b1;

	// {pin_a, pin_b, pin_push} per tick, meant for a debounce setting of 1
	localparam int DIRECTED_COUNT = 26;
	localparam logic [2:0] DIRECTED [0:DIRECTED_COUNT-1] = '{
		// settle everything to idle and high
		3'b111, 3'b111, 3'b111, 3'b111,
		// tie goes to A, failed switch fall, failed A rise, then anticlockwise step
		3'b000, 3'b001, 3'b101, 3'b001, 3'b101, 3'b111,
		// B first, A ignored while B owns, press, failed B rise, clockwise step, release
		3'b101, 3'b000, 3'b010, 3'b000, 3'b011, 3'b111,
		// failed A fall, failed B fall
		3'b011, 3'b111, 3'b101, 3'b111,
		// press, failed switch rise, release
		3'b110, 3'b110, 3'b111, 3'b110, 3'b111, 3'b111
	};

	typedef struct packed {
		code_t twist;
		code_t sw_ev;
		logic  direction;
		logic  level;
	} tick_report_t;

	// predicts one report per accepted tick and checks reports in order
	class encoder_scoreboard;
		deb_t         debounce;
		logic [2:0]   rot_phase;
		timer_t       rot_timer;
		logic         direction;
		logic [1:0]   sw_phase;
		timer_t       sw_timer;
		tick_report_t expected_reports[$];
		int           errors;

		function new();
			debounce  = DEBOUNCE_RESET;
			rot_phase = RP_IDLE;
			rot_timer = '0;
			direction = DIR_CW;
			sw_phase  = SP_HIGH;
			sw_timer  = '0;
			errors    = 0;
		endfunction

		function void write_register(logic idx, deb_t value);
			if (idx == REG_DEBOUNCE)
				debounce = value;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// saturating wait timer; true on the tick the pin is re-sampled
		function bit wait_over(inout timer_t t);
			if (t != '1)
				t = t + timer_t'(1);
			return (t >= debounce) || (t == '1);
		endfunction

		function void note_tick(logic a, logic b, logic sw);
			tick_report_t r;
			r.twist = TWIST_NONE;
			r.sw_ev = SW_NONE;

			// rotation debouncer, owner channel locks the other out
			case (rot_phase)
				RP_A_FALLWAIT: begin
					if (wait_over(rot_timer)) begin
						if (!a) begin
							rot_phase = RP_A_LOW;
							direction = DIR_ACW;
						end else
							rot_phase = RP_IDLE;
					end
				end
				RP_B_FALLWAIT: begin
					if (wait_over(rot_timer)) begin
						if (!b) begin
							rot_phase = RP_B_LOW;
							direction = DIR_CW;
						end else
							rot_phase = RP_IDLE;
					end
				end
				RP_A_LOW: begin
					if (a) begin
						rot_phase = RP_A_RISEWAIT;
						rot_timer = '0;
					end
				end
				RP_B_LOW: begin
					if (b) begin
						rot_phase = RP_B_RISEWAIT;
						rot_timer = '0;
					end
				end
				RP_A_RISEWAIT: begin
					if (wait_over(rot_timer)) begin
						if (a) begin
							rot_phase = RP_IDLE;
							r.twist   = TWIST_ACW;
						end else
							rot_phase = RP_A_LOW;
					end
				end
				RP_B_RISEWAIT: begin
					if (wait_over(rot_timer)) begin
						if (b) begin
							rot_phase = RP_IDLE;
							r.twist   = TWIST_CW;
						end else
							rot_phase = RP_B_LOW;
					end
				end
				default: begin
					rot_phase = RP_IDLE;
					if (!a) begin
						rot_phase = RP_A_FALLWAIT;
						rot_timer = '0;
					end else if (!b) begin
						rot_phase = RP_B_FALLWAIT;
						rot_timer = '0;
					end
				end
			endcase

			// switch debouncer
			case (sw_phase)
				SP_FALLWAIT: begin
					if (wait_over(sw_timer)) begin
						if (!sw) begin
							sw_phase = SP_LOW;
							r.sw_ev  = SW_PRESS;
						end else
							sw_phase = SP_HIGH;
					end
				end
				SP_LOW: begin
					if (sw) begin
						sw_phase = SP_RISEWAIT;
						sw_timer = '0;
					end
				end
				SP_RISEWAIT: begin
					if (wait_over(sw_timer)) begin
						if (sw) begin
							sw_phase = SP_HIGH;
							r.sw_ev  = SW_RELEASE;
						end else
							sw_phase = SP_LOW;
					end
				end
				default: begin
					sw_phase = SP_HIGH;
					if (!sw) begin
						sw_phase = SP_FALLWAIT;
						sw_timer = '0;
					end
				end
			endcase

			r.direction = direction;
			r.level     = (sw_phase == SP_HIGH) || (sw_phase == SP_FALLWAIT);
			expected_reports.push_back(r);
		endfunction

		function void check_report(code_t twist, code_t sw_ev, logic dir, logic lvl);
			tick_report_t want;
			if (expected_reports.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("%0t: report with none expected: twist %0d switch %0d dir %0d level %0d",
						$time, twist, sw_ev, dir, lvl);
				return;
			end
			want = expected_reports.pop_front();
			if (want.twist !== twist || want.sw_ev !== sw_ev || want.direction !== dir ||
					want.level !== lvl) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("%0t: report mismatch: expected twist %0d switch %0d dir %0d level %0d, got twist %0d switch %0d dir %0d level %0d",
						$time, want.twist, want.sw_ev, want.direction, want.level,
						twist, sw_ev, dir, lvl);
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_WIDTH-1:0] paddr;
	logic [APB_DATA_WIDTH-1:0] pwdata;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic                      pready;

	rotenc_sample_if sample_ch ();
	rotenc_report_if report_ch ();

	encoder_scoreboard board;

	int   src_idle_pct  = 31;
	int   snk_idle_pct  = 49;
	int   hold_requests = 0;
	int   holds_done    = 0;
	int   hold_left     = 0;
	int   ticks_sent    = 0;
	int   reg_errors    = 0;
	int   span          = 6;
	int   quiet         = 0;
	logic sw_lvl        = 1'b1;
	int   sw_left       = 10;

	rotary_encoder_debounce_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.report (report_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [APB_ADDR_WIDTH-1:0] reg_addr(input logic idx);
		return {idx, 2'b00};
	endfunction

	// apb write: setup phase, access phase, then the bus returns to idle
	task automatic apb_write(input logic idx, input logic [APB_DATA_WIDTH-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= reg_addr(idx);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic idx, output logic [APB_DATA_WIDTH-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= reg_addr(idx);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// debounce register must read back as predicted
	task automatic verify_register();
		logic [APB_DATA_WIDTH-1:0] rd;
		apb_read(REG_DEBOUNCE, rd);
		if (rd[DEB_WIDTH-1:0] !== board.debounce) begin
			reg_errors++;
			$display("%0t: debounce readback mismatch: expected %0d, got %0d",
				$time, board.debounce, rd[DEB_WIDTH-1:0]);
		end
	endtask

	// register write once every expected report is back
	task automatic write_setting(input logic idx, input deb_t value);
		logic [APB_DATA_WIDTH-1:0] wd;
		sample_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		wd = $urandom;
		wd[DEB_WIDTH-1:0] = value;
		apb_write(idx, wd);
		board.write_register(idx, value);
		verify_register();
		span = (board.debounce == 0) ? 1 : (board.debounce > 6 ? 6 : int'(board.debounce));
	endtask

	// one sample transaction, with random idle cycles in front
	task automatic send_tick(input logic a, input logic b, input logic sw);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.pin_a    <= a;
		sample_ch.pin_b    <= b;
		sample_ch.pin_push <= sw;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		board.note_tick(a, b, sw);
		ticks_sent++;
	endtask

	// switch random walk with occasional single-tick bounce
	function automatic logic next_switch();
		if (sw_left == 0) begin
			sw_lvl  = ~sw_lvl;
			sw_left = $urandom_range(1, 3 * span + 4);
		end
		sw_left--;
		if ($urandom_range(15) == 0)
			return ~sw_lvl;
		return sw_lvl;
	endfunction

	task automatic hold_levels(input logic a, input logic b, input int ticks);
		repeat (ticks) send_tick(a, b, next_switch());
	endtask

	// mostly full detents with random hold times, plus noise and aborted dips
	task automatic run_random(input int count);
		int         stop_at;
		int         kind;
		logic [7:0] path;
		logic [1:0] lv;
		logic [1:0] g;
		stop_at = ticks_sent + count;
		while (ticks_sent < stop_at) begin
			kind = $urandom_range(9);
			if (kind < 7) begin
				// {a,b} through one detent: B leads for clockwise, A for anticlockwise
				path = $urandom_range(1) ? 8'b10_00_01_11 : 8'b01_00_10_11;
				for (int i = 0; i < 4; i++) begin
					lv = path[7 - 2 * i -: 2];
					hold_levels(lv[1], lv[0], $urandom_range(1, 2 * span + 2));
					if ($urandom_range(7) == 0) begin
						g = lv ^ ($urandom_range(1) ? 2'b10 : 2'b01);
						hold_levels(g[1], g[0], 1);
					end
				end
			end else if (kind < 9) begin
				repeat ($urandom_range(1, 8))
					send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), next_switch());
			end else begin
				if ($urandom_range(1))
					hold_levels(1'b0, 1'b1, $urandom_range(1, span));
				else
					hold_levels(1'b1, 1'b0, $urandom_range(1, span));
				hold_levels(1'b1, 1'b1, $urandom_range(1, span));
			end
		end
	endtask

	// report sink: random stalls, plus long hold-offs on request
	initial begin
		report_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (report_ch.valid && report_ch.ready)
				board.check_report(report_ch.twist_event, report_ch.switch_event,
					report_ch.last_direction, report_ch.switch_level);
			if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				report_ch.ready <= 1'b0;
			end else
				report_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// watchdog on cycles with no transaction on either channel
	initial begin
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (report_ch.valid && report_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// stimulus
	initial begin
		board              = new();
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		sample_ch.valid    = 1'b0;
		sample_ch.pin_a    = 1'b1;
		sample_ch.pin_b    = 1'b1;
		sample_ch.pin_push = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting, then directed ticks at the shortest wait
		verify_register();
		run_random(20);
		write_setting(REG_DEBOUNCE, 16'd1);
		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_tick(DIRECTED[i][2], DIRECTED[i][1], DIRECTED[i][0]);

		write_setting(REG_DEBOUNCE, 16'd2);
		run_random(110);
		write_setting(REG_DEBOUNCE, 16'd0);
		run_random(110);
		write_setting(REG_DEBOUNCE, 16'd3);
		run_random(110);

		src_idle_pct = 49;
		snk_idle_pct = 31;
		write_setting(REG_DEBOUNCE, 16'd1);
		run_random(110);
		write_setting(REG_DEBOUNCE, 16'd4);
		run_random(110);
		// write to an unmapped register must change nothing
		write_setting(REG_UNUSED, deb_t'($urandom));
		run_random(20);
		write_setting(REG_DEBOUNCE, 16'd6);
		run_random(110);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_setting(REG_DEBOUNCE, 16'd2);
		hold_requests++;
		run_random(130);
		write_setting(REG_DEBOUNCE, 16'd5);
		run_random(110);
		write_setting(REG_DEBOUNCE, 16'd65535);
		run_random(40);
		write_setting(REG_DEBOUNCE, 16'd1);
		run_random(40);

		// drain
		sample_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && reg_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rotenc_pkg.sv
rtl/core/rotenc_sample_if.sv
rtl/core/rotenc_report_if.sv
rtl/core/rotenc_apb.sv
rtl/core/rotenc_rot.sv
rtl/core/rotenc_sw.sv
rtl/core/rotary_encoder_debounce_decoder.sv
rtl/core/rotenc_checker.sv
verif/tb.sv
